[rtl/core/deque_with_undo_last_insert_defines.svh]
// -----------------------------------------------------------------------------
// deque_with_undo_last_insert_defines.svh
// Assertion macros used by the deque top module.
// -----------------------------------------------------------------------------
`ifndef DEQUE_WITH_UNDO_LAST_INSERT_DEFINES_SVH
`define DEQUE_WITH_UNDO_LAST_INSERT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define DQU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition in one cycle that forces another in the same cycle.
`define DQU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define DQU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dqu_pkg.sv]
// -----------------------------------------------------------------------------
// dqu_pkg
// Types and codes shared by the deque with undo of the last insertion.
// -----------------------------------------------------------------------------
package dqu_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 8;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Operation codes of an input transaction.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_UNDO       = 2'd2,
        KIND_READ       = 2'd3
    } t_kind;

    // Status codes of a result transaction.
    typedef enum logic [STAT_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_UNDO_EMPTY = 2'd1,
        STATUS_PUSH_FULL  = 2'd2,
        STATUS_RANGE      = 2'd3
    } t_status;

    // Result fields that the control logic computes for one transaction.
    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
        logic                 read_ok;
    } t_result;

endpackage

[rtl/core/deque_with_undo_last_insert.sv]
// -----------------------------------------------------------------------------
// deque_with_undo_last_insert
// Bounded byte deque in a ring buffer with undo of the latest insertion.
//
// Input channel (i_valid/o_ready) carries one operation per transaction:
// push back, push front, undo the newest insertion still held, or read the
// byte at an offset from the front. Output channel (o_valid/i_ready) carries
// exactly one result per input transaction: status, entry count, empty flag
// and the byte read (zero unless a read succeeds).
// The result passes through one input register, then the result register
// together with the registered byte memory read. Throughput is one
// transaction per cycle while the receiver takes results; the fill count
// and front pointer that the next operation needs are updated as each
// transaction advances.
// When the receiver stalls, the result holds and the input register fills;
// o_ready then drops until the result is taken.
// Reset clears the count, the front pointer and both pipeline valids; the
// storage is not cleared, since only held entries are ever read.
// -----------------------------------------------------------------------------
`include "deque_with_undo_last_insert_defines.svh"

module deque_with_undo_last_insert
    import dqu_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic [POS_W-1:0]   i_position,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic               o_is_empty,
    output logic [DATA_W-1:0]  o_read_byte
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input register.
    logic              r_in_valid;
    t_kind             r_kind;
    logic [DATA_W-1:0] r_data_byte;
    logic [POS_W-1:0]  r_position;

    // Result register.
    logic              r_out_valid;
    t_result           r_res;

    logic              adv;
    logic              in_accept;
    t_result           n_res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Handshake: the input register moves on when the result slot is free.
    assign adv       = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || adv;
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= t_kind'(i_kind);
            r_data_byte <= i_data_byte;
            r_position  <= i_position;
        end
    end

    // Control and pointer logic.
    dqu_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_kind      (r_kind),
        .i_data_byte (r_data_byte),
        .i_position  (r_position),
        .o_res       (n_res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr)
    );

    // Byte storage.
    dqu_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_res.status;
    assign o_entry_count = r_res.entry_count;
    assign o_is_empty    = r_res.is_empty;
    assign o_read_byte   = r_res.read_ok ? ram_rdata : '0;

    // Design checks.
    `DQU_ASSERT_NEXT(a_adv_gives_result, adv, r_out_valid,
        "advanced transaction did not reach the result register")
    `DQU_ASSERT_SAME(a_bad_status_no_byte, r_out_valid && (r_res.status != STATUS_OK),
        o_read_byte == '0, "read byte nonzero on a failed transaction")
    `DQU_ASSERT_SAME(a_full_count, r_out_valid && (r_res.status == STATUS_PUSH_FULL),
        r_res.entry_count == COUNT_W'(DEPTH), "push dropped while not full")
    `DQU_ASSERT_SAME(a_undo_empty_flag, r_out_valid && (r_res.status == STATUS_UNDO_EMPTY),
        r_res.is_empty && (r_res.entry_count == '0), "undo ignored while not empty")

endmodule

[rtl/core/dqu_ram.sv]
// -----------------------------------------------------------------------------
// dqu_ram
// Byte storage of the ring buffer: one write port, one read port, registered
// read data.
// -----------------------------------------------------------------------------
module dqu_ram
    import dqu_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/dqu_ctrl.sv]
// -----------------------------------------------------------------------------
// dqu_ctrl
// Front pointer, fill count and push-side stack. Decides each transaction,
// produces its result fields and the byte memory accesses.
// -----------------------------------------------------------------------------
module dqu_ctrl
    import dqu_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_kind             i_kind,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic [POS_W-1:0]  i_position,
    output t_result           o_res,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic [AW-1:0]     o_raddr
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int SW   = ((AW > POS_W) ? AW : POS_W) + 1;

    // Architectural state.
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Side stack: the top two bits live in registers, the rest in memory.
    // r_side_rd holds the entry two below the top, whenever the stack has one.
    logic          r_side_top, n_side_top;
    logic          r_side_nxt, n_side_nxt;
    logic          r_side_rd;
    logic          r_side_mem [DEPTH];
    logic          side_we;
    logic [CW-1:0] side_cnt;
    logic [CW-1:0] side_raddr;

    logic          full;
    logic          empty;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] read_sum;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] read_slot;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // Ring slot arithmetic; both sums stay below twice the depth when DEPTH >= 64.
    always_comb begin
        back_sum = SW'(r_front) + SW'(r_count);
        if (back_sum >= SW'(DEPTH)) begin
            back_sum = back_sum - SW'(DEPTH);
        end
        read_sum = SW'(r_front) + SW'(i_position);
        if (read_sum >= SW'(DEPTH)) begin
            read_sum = read_sum - SW'(DEPTH);
        end
    end

    assign back_slot = back_sum[AW-1:0];
    assign read_slot = read_sum[AW-1:0];
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : (r_front + AW'(1));

    // Decision for the transaction in the input register.
    always_comb begin
        n_front          = r_front;
        n_count          = r_count;
        n_side_top       = r_side_top;
        n_side_nxt       = r_side_nxt;
        side_we          = 1'b0;
        o_we             = 1'b0;
        o_waddr          = back_slot;
        o_res.status     = STATUS_OK;
        o_res.read_ok    = 1'b0;
        case (i_kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (full) begin
                    o_res.status = STATUS_PUSH_FULL;
                end else begin
                    o_we       = i_adv;
                    side_we    = i_adv;
                    n_count    = r_count + CW'(1);
                    n_side_top = (i_kind == KIND_PUSH_FRONT);
                    n_side_nxt = r_side_top;
                    if (i_kind == KIND_PUSH_FRONT) begin
                        n_front = front_dec;
                        o_waddr = front_dec;
                    end
                end
            end
            KIND_UNDO: begin
                if (empty) begin
                    o_res.status = STATUS_UNDO_EMPTY;
                end else begin
                    n_count    = r_count - CW'(1);
                    n_side_top = r_side_nxt;
                    n_side_nxt = r_side_rd;
                    if (r_side_top) begin
                        n_front = front_inc;
                    end
                end
            end
            KIND_READ: begin
                if (CMPW'(i_position) >= CMPW'(r_count)) begin
                    o_res.status = STATUS_RANGE;
                end else begin
                    o_res.read_ok = 1'b1;
                end
            end
            default: begin
                o_res.status = STATUS_OK;
            end
        endcase
        o_res.entry_count = COUNT_W'(n_count);
        o_res.is_empty    = (n_count == '0);
    end

    assign o_wdata = i_data_byte;
    assign o_raddr = read_slot;

    // Address of the side entry two below the top that holds after this edge.
    // Without an advance the count stays, so the cached entry must stay too.
    assign side_cnt   = i_adv ? n_count : r_count;
    assign side_raddr = (side_cnt >= CW'(3)) ? (side_cnt - CW'(3)) : '0;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_adv) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Cached top of the side stack.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side_top <= n_side_top;
            r_side_nxt <= n_side_nxt;
        end
    end

    // Side stack memory: a push writes at the old count.
    always_ff @(posedge i_clk) begin
        if (side_we) begin
            r_side_mem[r_count[AW-1:0]] <= n_side_top;
        end
        r_side_rd <= r_side_mem[side_raddr[AW-1:0]];
    end

endmodule

[sim/testbench.sv]
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte deque with undo of the latest insertion.
// A short table of directed operations covers the empty, single-byte and
// out-of-range cases. Random segments follow that fill, drain or mix the
// deque. Both handshakes idle at random, and one long receiver hold-off
// backs the pipeline up into the input. Every result is compared against a
// behavioral deque kept alongside the block or a checked row's typed result.
// -----------------------------------------------------------------------------
module testbench;
    import dqu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_OFF     = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_DIRECTED = 21;

    // Expected fields of one result transaction.
    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic [DATA_W-1:0]  read_byte;
    } t_deque_result;

    // One row of the directed table; the result is typed in when checked is set.
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              checked;
        t_deque_result     result;
    } t_directed_row;

    // Biases of the random segments.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_traffic_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [KIND_W-1:0]  i_kind        = '0;
    logic [DATA_W-1:0]  i_data_byte   = '0;
    logic [POS_W-1:0]   i_position    = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [COUNT_W-1:0] o_entry_count;
    logic               o_is_empty;
    logic [DATA_W-1:0]  o_read_byte;

    // Shadow copy of the deque contents and pointers.
    logic [DATA_W-1:0]  shadow_bytes [DEPTH];
    logic               shadow_sides [DEPTH];
    logic [POS_W-1:0]   shadow_front = '0;
    logic [COUNT_W-1:0] shadow_count = '0;

    t_deque_result pending_results [$];
    int            error_count   = 0;
    int            results_seen  = 0;
    int            cycle_count   = 0;

    // Empty-deque, single-byte, ordering and range cases.
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{KIND_UNDO,       8'hFF, 6'd63, 1'b1, '{STATUS_UNDO_EMPTY, 7'd0, 1'b1, 8'h00}},
        '{KIND_READ,       8'h00, 6'd0,  1'b1, '{STATUS_RANGE,      7'd0, 1'b1, 8'h00}},
        '{KIND_READ,       8'hFF, 6'd63, 1'b1, '{STATUS_RANGE,      7'd0, 1'b1, 8'h00}},
        '{KIND_PUSH_BACK,  8'h00, 6'd63, 1'b1, '{STATUS_OK,         7'd1, 1'b0, 8'h00}},
        '{KIND_PUSH_FRONT, 8'hFF, 6'd0,  1'b1, '{STATUS_OK,         7'd2, 1'b0, 8'h00}},
        '{KIND_PUSH_BACK,  8'hA5, 6'd21, 1'b1, '{STATUS_OK,         7'd3, 1'b0, 8'h00}},
        '{KIND_READ,       8'h3C, 6'd0,  1'b0, '0},
        '{KIND_READ,       8'h00, 6'd1,  1'b0, '0},
        '{KIND_READ,       8'hFF, 6'd2,  1'b0, '0},
        '{KIND_READ,       8'h00, 6'd3,  1'b1, '{STATUS_RANGE,      7'd3, 1'b0, 8'h00}},
        '{KIND_READ,       8'h00, 6'd63, 1'b1, '{STATUS_RANGE,      7'd3, 1'b0, 8'h00}},
        '{KIND_PUSH_FRONT, 8'h5A, 6'd42, 1'b0, '0},
        '{KIND_UNDO,       8'h77, 6'd0,  1'b0, '0},
        '{KIND_READ,       8'h00, 6'd0,  1'b0, '0},
        '{KIND_UNDO,       8'h00, 6'd0,  1'b0, '0},
        '{KIND_UNDO,       8'h00, 6'd0,  1'b0, '0},
        '{KIND_READ,       8'h00, 6'd0,  1'b0, '0},
        '{KIND_UNDO,       8'h00, 6'd0,  1'b1, '{STATUS_OK,         7'd0, 1'b1, 8'h00}},
        '{KIND_PUSH_FRONT, 8'h80, 6'd0,  1'b1, '{STATUS_OK,         7'd1, 1'b0, 8'h00}},
        '{KIND_UNDO,       8'h00, 6'd0,  1'b1, '{STATUS_OK,         7'd0, 1'b1, 8'h00}},
        '{KIND_UNDO,       8'h00, 6'd0,  1'b1, '{STATUS_UNDO_EMPTY, 7'd0, 1'b1, 8'h00}}
    };

    deque_with_undo_last_insert #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_read_byte   (o_read_byte)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow deque and returns its result.
    function automatic t_deque_result apply_deque_op(t_kind kind, logic [DATA_W-1:0] data,
                                                     logic [POS_W-1:0] pos);
        t_deque_result    res;
        logic [POS_W-1:0] slot;
        res.status    = STATUS_OK;
        res.read_byte = '0;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (shadow_count >= COUNT_W'(DEPTH)) begin
                    res.status = STATUS_PUSH_FULL;
                end else begin
                    if (kind == KIND_PUSH_BACK) begin
                        slot = shadow_front + shadow_count[POS_W-1:0];
                        shadow_bytes[slot] = data;
                        shadow_sides[shadow_count[POS_W-1:0]] = 1'b0;
                    end else begin
                        shadow_front = shadow_front - 1'b1;
                        shadow_bytes[shadow_front] = data;
                        shadow_sides[shadow_count[POS_W-1:0]] = 1'b1;
                    end
                    shadow_count = shadow_count + 1'b1;
                end
            end
            KIND_UNDO: begin
                if (shadow_count == '0) begin
                    res.status = STATUS_UNDO_EMPTY;
                end else begin
                    // The newest byte sits at the end its side bit names.
                    shadow_count = shadow_count - 1'b1;
                    if (shadow_sides[shadow_count[POS_W-1:0]]) begin
                        shadow_front = shadow_front + 1'b1;
                    end
                end
            end
            default: begin
                if ({1'b0, pos} >= shadow_count) begin
                    res.status = STATUS_RANGE;
                end else begin
                    slot = shadow_front + pos;
                    res.read_byte = shadow_bytes[slot];
                end
            end
        endcase
        res.entry_count = shadow_count;
        res.is_empty    = (shadow_count == '0);
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Draws one random operation, biased by the segment mode.
    task automatic pick_random_op(input t_traffic_mode mode, output t_kind kind,
                                  output logic [DATA_W-1:0] data,
                                  output logic [POS_W-1:0] pos);
        int r;
        int push_lim;
        int read_lim;
        r    = $urandom_range(0, 99);
        data = DATA_W'($urandom_range(0, 255));
        pos  = POS_W'($urandom_range(0, 63));
        case (mode)
            MODE_FILL:  begin push_lim = 80; read_lim = 92; end
            MODE_DRAIN: begin push_lim = 30; read_lim = 55; end
            default:    begin push_lim = 50; read_lim = 75; end
        endcase
        if (r < 10) begin
            kind = t_kind'($urandom_range(0, 3));
        end else if (r < push_lim) begin
            kind = ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else if (r < read_lim) begin
            kind = KIND_READ;
        end else begin
            kind = KIND_UNDO;
        end
        // Reads mostly target held bytes, with the last one favored now and then.
        if (kind == KIND_READ && shadow_count != '0 && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 5) == 0) begin
                pos = POS_W'(shadow_count - 1'b1);
            end else begin
                pos = POS_W'($urandom_range(0, int'(shadow_count) - 1));
            end
        end
    endtask

    // Offers one transaction, waits for acceptance and records its expectation.
    task automatic send_op(input t_kind kind, input logic [DATA_W-1:0] data,
                           input logic [POS_W-1:0] pos, input logic checked,
                           input t_deque_result typed_result);
        t_deque_result res;
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        i_position  <= pos;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        res = apply_deque_op(kind, data, pos);
        pending_results.push_back(checked ? typed_result : res);
    endtask

    // Optional pause on the input side after an accepted transaction.
    task automatic input_idle(input bit no_idle);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Reset, directed table, random segments, then drain and report.
    initial begin
        t_kind             kind;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        t_traffic_mode     mode;
        int                sent;
        int                seg_len;
        bit                no_idle;
        bit                first_seg;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].kind, directed_rows[i].data_byte,
                    directed_rows[i].position, directed_rows[i].checked,
                    directed_rows[i].result);
            input_idle(1'b0);
        end

        sent      = 0;
        first_seg = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            // The first segment always fills, so the full case comes early.
            mode      = first_seg ? MODE_FILL : t_traffic_mode'($urandom_range(0, 2));
            seg_len   = first_seg ? 90 : $urandom_range(20, 90);
            no_idle   = ($urandom_range(0, 3) == 0);
            first_seg = 1'b0;
            for (int j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
                pick_random_op(mode, kind, data, pos);
                send_op(kind, data, pos, 1'b0, '0);
                sent++;
                input_idle(no_idle);
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Output-side flow control, including one long hold-off.
    initial begin
        bit pressure_done;
        int gap;
        pressure_done = 1'b0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (!pressure_done && results_seen >= 250) begin
                pressure_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat (100) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_deque_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status=%0d count=%0d",
                       o_status, o_entry_count);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                    error_count++;
                end
                if (o_entry_count !== exp_res.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           exp_res.entry_count, o_entry_count);
                    error_count++;
                end
                if (o_is_empty !== exp_res.is_empty) begin
                    $error("is_empty: expected %0d, actual %0d", exp_res.is_empty, o_is_empty);
                    error_count++;
                end
                if (o_read_byte !== exp_res.read_byte) begin
                    $error("read_byte: expected 0x%02h, actual 0x%02h",
                           exp_res.read_byte, o_read_byte);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dqu_pkg.sv
rtl/core/dqu_ram.sv
rtl/core/dqu_ctrl.sv
rtl/core/deque_with_undo_last_insert.sv
sim/testbench.sv
